// ===== sv/matrix_chain_min_cost_defines.svh =====
// ----------------------------------------------------------------------------
// matrix_chain_min_cost_defines.svh
// Assertion macros used by the checker file of the matrix chain cost block.
// ----------------------------------------------------------------------------
`ifndef MATRIX_CHAIN_MIN_COST_DEFINES_SVH
`define MATRIX_CHAIN_MIN_COST_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mcm_pkg.sv =====
// ----------------------------------------------------------------------------
// mcm_pkg
// Sizes, controller states and command/status types of the matrix chain block.
// ----------------------------------------------------------------------------
package mcm_pkg;

  localparam int MAX_DIMS   = 64;
  localparam int DIM_W      = 12;
  localparam int COST_W     = 48;
  localparam int IDX_W      = $clog2(MAX_DIMS);
  localparam int CNT_W      = $clog2(MAX_DIMS + 1);
  localparam int CADDR_W    = 2 * IDX_W;
  localparam int COST_DEPTH = MAX_DIMS * MAX_DIMS;
  localparam int PIJ_W      = 2 * DIM_W;
  localparam int PROD_W     = 3 * DIM_W;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_I,
    ST_RD_J,
    ST_INIT,
    ST_STEP,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic accept;       // input transaction this cycle
    logic take_last;    // accepted item closes the chain
    logic rd_i;         // read p(i)
    logic rd_j;         // read p(j), capture p(i)
    logic cell_init;    // form p(i)*p(j), reset best, k = i+1
    logic step;         // issue split point k
    logic write_cell;   // store best as cost(i,j)
    logic start_len;    // len = 2, i = 0
    logic next_i;
    logic next_len;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic short_chain;  // chain would hold fewer than three values
    logic k_last;
    logic pipe_busy;
    logic i_last;
    logic len_last;
    logic out_busy;
  } stat_t;

endpackage

// ===== sv/mcm_if.sv =====
// ----------------------------------------------------------------------------
// mcm_in_if / mcm_out_if
// Valid/ready channels carrying chain values in and cost results out.
// ----------------------------------------------------------------------------
interface mcm_in_if;
  logic                      valid;
  logic                      ready;
  logic [mcm_pkg::DIM_W-1:0] dim_value;
  logic                      last_value;

  modport source (output valid, output dim_value, output last_value, input ready);
  modport sink   (input valid, input dim_value, input last_value, output ready);
endinterface

interface mcm_out_if;
  logic                       valid;
  logic                       ready;
  logic [mcm_pkg::COST_W-1:0] min_cost;
  logic                       overflow;

  modport source (output valid, output min_cost, output overflow, input ready);
  modport sink   (input valid, input min_cost, input overflow, output ready);
endinterface

// ===== sv/mcm_ram.sv =====
// ----------------------------------------------------------------------------
// mcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcm_ctrl
// Sequencer: loads the chain, walks span/start/split loops, hands off result.
// ----------------------------------------------------------------------------
module mcm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  input  logic           out_ready,
  input  mcm_pkg::stat_t stat,
  output logic           in_ready,
  output mcm_pkg::cmd_t  cmd
);

  mcm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      mcm_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.accept    = in_valid;
        cmd.take_last = in_valid & in_last;
        if (cmd.take_last) begin
          if (stat.short_chain) begin
            state_nxt = mcm_pkg::ST_RESULT;
          end else begin
            cmd.start_len = 1'b1;
            state_nxt     = mcm_pkg::ST_RD_I;
          end
        end
      end
      mcm_pkg::ST_RD_I: begin
        cmd.rd_i  = 1'b1;
        state_nxt = mcm_pkg::ST_RD_J;
      end
      mcm_pkg::ST_RD_J: begin
        cmd.rd_j  = 1'b1;
        state_nxt = mcm_pkg::ST_INIT;
      end
      mcm_pkg::ST_INIT: begin
        cmd.cell_init = 1'b1;
        state_nxt     = mcm_pkg::ST_STEP;
      end
      mcm_pkg::ST_STEP: begin
        cmd.step = 1'b1;
        if (stat.k_last) begin
          state_nxt = mcm_pkg::ST_DRAIN;
        end
      end
      mcm_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.write_cell = 1'b1;
          priority if (!stat.i_last) begin
            cmd.next_i = 1'b1;
            state_nxt  = mcm_pkg::ST_RD_I;
          end else if (!stat.len_last) begin
            cmd.next_len = 1'b1;
            state_nxt    = mcm_pkg::ST_RD_I;
          end else begin
            state_nxt = mcm_pkg::ST_RESULT;
          end
        end
      end
      mcm_pkg::ST_RESULT: begin
        if (!stat.out_busy || out_ready) begin
          cmd.load_result = 1'b1;
          state_nxt       = mcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mcm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/mcm_dp.sv =====
// ----------------------------------------------------------------------------
// mcm_dp
// Datapath: value store, cost table, loop counters, split-point pipeline and
// the result register.
// ----------------------------------------------------------------------------
module mcm_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mcm_pkg::cmd_t               cmd,
  input  logic [mcm_pkg::DIM_W-1:0]   in_dim,
  input  logic                        out_ready,
  output mcm_pkg::stat_t              stat,
  output logic                        out_valid,
  output logic [mcm_pkg::COST_W-1:0]  out_cost,
  output logic                        out_ovf
);

  localparam int CNT_W  = mcm_pkg::CNT_W;
  localparam int IDX_W  = mcm_pkg::IDX_W;
  localparam int COST_W = mcm_pkg::COST_W;

  // chain load state
  logic [CNT_W-1:0]  count_r;
  logic              ovf_r;
  logic [CNT_W-1:0]  n_r;
  logic              ovf_res_r;
  logic              room;

  // loop counters
  logic [CNT_W-1:0]  len_r;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  k_r;
  logic [CNT_W-1:0]  j_full;
  logic [IDX_W-1:0]  j_idx;
  logic              k_last;
  logic              left_pair;

  // memories
  logic [IDX_W-1:0]              dim_raddr;
  logic [mcm_pkg::DIM_W-1:0]     dim_rd;
  logic [COST_W-1:0]             costa_rd;
  logic [COST_W-1:0]             costb_rd;
  logic [mcm_pkg::CADDR_W-1:0]   cell_addr;

  // split pipeline
  logic [mcm_pkg::DIM_W-1:0]     pi_r;
  logic [mcm_pkg::PIJ_W-1:0]     pij_r;
  logic                          v1_r, v2_r;
  logic                          lz1_r, rz1_r;
  logic [COST_W-1:0]             sum_r, sum_nxt;
  logic [mcm_pkg::PROD_W-1:0]    prod_r;
  logic [COST_W-1:0]             best_r;
  logic [COST_W-1:0]             cand;
  logic [COST_W:0]               add1, add2;
  logic [COST_W-1:0]             term_a, term_b;

  // result register
  logic                          out_valid_r;
  logic [COST_W-1:0]             out_cost_r;
  logic                          out_ovf_r;

  assign room      = count_r < CNT_W'(mcm_pkg::MAX_DIMS);
  assign j_full    = CNT_W'(i_r) + len_r;
  assign j_idx     = j_full[IDX_W-1:0];
  assign k_last    = (CNT_W'(k_r) + CNT_W'(1)) == j_full;
  assign left_pair = CNT_W'(k_r) == (CNT_W'(i_r) + CNT_W'(1));
  assign cell_addr = {i_r, j_idx};

  always_comb begin
    priority if (cmd.rd_i) begin
      dim_raddr = i_r;
    end else if (cmd.rd_j) begin
      dim_raddr = j_idx;
    end else begin
      dim_raddr = k_r;
    end
  end

  mcm_ram #(.WIDTH(mcm_pkg::DIM_W), .DEPTH(mcm_pkg::MAX_DIMS)) u_dim_ram (
    .clk  (clk),
    .we   (cmd.accept & room),
    .waddr(count_r[IDX_W-1:0]),
    .wdata(in_dim),
    .raddr(dim_raddr),
    .rdata(dim_rd)
  );

  // two copies of the cost table: left and right sub-chain read together
  mcm_ram #(.WIDTH(COST_W), .DEPTH(mcm_pkg::COST_DEPTH)) u_cost_a_ram (
    .clk  (clk),
    .we   (cmd.write_cell),
    .waddr(cell_addr),
    .wdata(best_r),
    .raddr({i_r, k_r}),
    .rdata(costa_rd)
  );

  mcm_ram #(.WIDTH(COST_W), .DEPTH(mcm_pkg::COST_DEPTH)) u_cost_b_ram (
    .clk  (clk),
    .we   (cmd.write_cell),
    .waddr(cell_addr),
    .wdata(best_r),
    .raddr({k_r, j_idx}),
    .rdata(costb_rd)
  );

  // chain loading
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.take_last) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.accept) begin
      if (room) begin
        count_r <= count_r + CNT_W'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_last) begin
      n_r       <= room ? count_r + CNT_W'(1) : count_r;
      ovf_res_r <= ovf_r | ~room;
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (cmd.start_len) begin
      len_r <= CNT_W'(2);
      i_r   <= '0;
    end else if (cmd.next_len) begin
      len_r <= len_r + CNT_W'(1);
      i_r   <= '0;
    end else if (cmd.next_i) begin
      i_r <= i_r + IDX_W'(1);
    end
    if (cmd.cell_init) begin
      k_r <= i_r + IDX_W'(1);
    end else if (cmd.step) begin
      k_r <= k_r + IDX_W'(1);
    end
  end

  // cell setup
  always_ff @(posedge clk) begin
    if (cmd.rd_j) begin
      pi_r <= dim_rd;
    end
    if (cmd.cell_init) begin
      pij_r <= mcm_pkg::PIJ_W'(pi_r) * mcm_pkg::PIJ_W'(dim_rd);
    end
  end

  // stage 1: sub-chain costs summed, dimension product formed
  // cost(i,i+1) and cost(k,k+1) are zero and never stored
  assign term_a  = lz1_r ? '0 : costa_rd;
  assign term_b  = rz1_r ? '0 : costb_rd;
  assign add1    = {1'b0, term_a} + {1'b0, term_b};
  assign sum_nxt = add1[COST_W] ? mcm_pkg::COST_MAX : add1[COST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.step;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    lz1_r  <= left_pair;
    rz1_r  <= k_last;
    sum_r  <= sum_nxt;
    prod_r <= mcm_pkg::PROD_W'(pij_r) * mcm_pkg::PROD_W'(dim_rd);
  end

  // stage 2: total and running minimum
  assign add2 = {1'b0, sum_r} + (COST_W + 1)'(prod_r);
  assign cand = add2[COST_W] ? mcm_pkg::COST_MAX : add2[COST_W-1:0];

  always_ff @(posedge clk) begin
    priority if (cmd.take_last) begin
      best_r <= '0;
    end else if (cmd.cell_init) begin
      best_r <= mcm_pkg::COST_MAX;
    end else if (v2_r && (cand < best_r)) begin
      best_r <= cand;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_cost_r <= best_r;
      out_ovf_r  <= ovf_res_r;
    end
  end

  assign stat.short_chain = count_r < CNT_W'(2);
  assign stat.k_last      = k_last;
  assign stat.pipe_busy   = v1_r | v2_r;
  assign stat.i_last      = (j_full + CNT_W'(1)) == n_r;
  assign stat.len_last    = (len_r + CNT_W'(1)) == n_r;
  assign stat.out_busy    = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_cost  = out_cost_r;
  assign out_ovf   = out_ovf_r;

endmodule

// ===== sv/matrix_chain_min_cost.sv =====
// ----------------------------------------------------------------------------
// matrix_chain_min_cost
// Minimum scalar multiplication count of a matrix chain, from its dimensions.
//
//   channel  dir  payload                 transaction
//   in_ch    in   dim_value, last_value   one chain dimension
//   out_ch   out  min_cost, overflow      one result per chain
//
// Flow: values load at one per cycle. After the last one, the cost table is
// filled one split point per cycle by a two-stage add/compare pipeline; each
// cell reads p(i) and p(j), forms their product, issues its split points and
// drains the pipeline before it is written. Chains of one or two values skip
// the fill and go straight to the result.
// Reset: synchronous, active low; no memory clearing pass is needed.
// Stalls: in_ch.ready is low from the last value until the result moves into
// the output register; a held result does not block loading the next chain.
// ----------------------------------------------------------------------------
module matrix_chain_min_cost (
  input  logic      clk,
  input  logic      rst_n,
  mcm_in_if.sink    in_ch,
  mcm_out_if.source out_ch
);

  mcm_pkg::cmd_t  cmd;
  mcm_pkg::stat_t stat;

  // sequencer: owns in_ch.ready and all loop decisions
  mcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_value),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // datapath: value store, cost table copies, split pipeline, output register
  mcm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_dim   (in_ch.dim_value),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .out_valid(out_ch.valid),
    .out_cost (out_ch.min_cost),
    .out_ovf  (out_ch.overflow)
  );

endmodule

// ===== sv/mcm_checker.sv =====
// ----------------------------------------------------------------------------
// mcm_checker
// Port-level checks of the matrix chain cost block, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_chain_min_cost_defines.svh"

module mcm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mcm_pkg::COST_W-1:0] min_cost,
  input logic                       overflow
);

  // a closing value starts the computation, so intake stops
  `MCM_ASSERT_NEXT(a_last_blocks_input, in_valid && in_ready && in_last, !in_ready, "input still ready after last value")

  // a new result is only loaded while intake is held off
  `MCM_ASSERT_NOW(a_result_after_compute, $rose(out_valid), !$past(in_ready), "result appeared while accepting values")

  // a stalled result stays put
  `MCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(min_cost) && $stable(overflow), "result changed under stall")

endmodule

bind matrix_chain_min_cost mcm_checker u_mcm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .in_last  (in_ch.last_value),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .min_cost (out_ch.min_cost),
  .overflow (out_ch.overflow)
);
